// ===== rtl/gdp_pkg.sv =====
// ----------------------------------------------------------------------------
// gdp_pkg: shared types and constants for the dead-end pruner
// Widths, command codes and the control/status structs between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package gdp_pkg;

   // storage geometry
   localparam int MaxNodes = 64;
   localparam int NodeW    = $clog2(MaxNodes);
   localparam int CountW   = NodeW + 1;

   // register indexes on the configuration port
   localparam logic [1:0] REG_NODE_COUNT = 2'd0;
   localparam logic [1:0] REG_START_NODE = 2'd1;
   localparam logic [1:0] REG_END_NODE   = 2'd2;

   // input item kinds
   localparam logic OP_WRITE_EDGE = 1'b0;
   localparam logic OP_PRUNE      = 1'b1;

   // datapath commands
   localparam logic [3:0] CMD_NONE  = 4'd0;
   localparam logic [3:0] CMD_LATCH = 4'd1;
   localparam logic [3:0] CMD_RD_A  = 4'd2;
   localparam logic [3:0] CMD_WR_A  = 4'd3;
   localparam logic [3:0] CMD_RD_B  = 4'd4;
   localparam logic [3:0] CMD_WR_B  = 4'd5;
   localparam logic [3:0] CMD_PINIT = 4'd6;
   localparam logic [3:0] CMD_RD_I  = 4'd7;
   localparam logic [3:0] CMD_CHECK = 4'd8;
   localparam logic [3:0] CMD_RD_J  = 4'd9;
   localparam logic [3:0] CMD_WR_J  = 4'd10;
   localparam logic [3:0] CMD_COUNT = 4'd11;
   localparam logic [3:0] CMD_FIND  = 4'd12;
   localparam logic [3:0] CMD_OLAT  = 4'd13;
   localparam logic [3:0] CMD_GATH  = 4'd14;
   localparam logic [3:0] CMD_LOAD  = 4'd15;

   typedef struct packed {
      logic [3:0] code;
   } cmd_type;

   typedef struct packed {
      logic req_op;      // kind of the item on offer
      logic hit;         // row under check is a dead end
      logic scan_last;   // scan pointer at the last node in use
      logic sweep_last;  // sweep pointer at the last column
      logic i_live;      // node under the pointer survives
      logic i_last;      // node pointer at the last storage row
      logic out_free;    // result register can take a new item
   } status_type;

   // one-hot bit for a node index
   function automatic logic [MaxNodes-1:0] node_bit(input logic [NodeW-1:0] idx);
      logic [MaxNodes-1:0] v;
      v = '0;
      v[idx] = 1'b1;
      return v;
   endfunction

endpackage

// ===== rtl/gdp_ram.sv =====
// ----------------------------------------------------------------------------
// gdp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gdp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/gdp_datapath.sv =====
// ----------------------------------------------------------------------------
// gdp_datapath: adjacency store, live set, counters and result register
// Executes one command per cycle from the controller.
// ----------------------------------------------------------------------------
module gdp_datapath (
   input  logic                clock,
   input  logic                reset,
   input  gdp_pkg::cmd_type    cmd,
   output gdp_pkg::status_type status,
   input  logic [15:0]         req_tdata,
   input  logic                req_tuser,
   input  logic                csr_valid,
   input  logic [1:0]          csr_index,
   input  logic [6:0]          csr_wdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [103:0]        rsp_tdata,
   output logic                rsp_tlast
);

   localparam int N  = gdp_pkg::MaxNodes;
   localparam int NW = gdp_pkg::NodeW;
   localparam int CW = gdp_pkg::CountW;

   // configuration
   logic [CW-1:0] count_ff, count_in;
   logic [NW-1:0] start_ff, start_in, end_ff, end_in;

   // latched edge write
   logic [NW-1:0] a_ff, a_in, b_ff, b_in;
   logic          conn_ff, conn_in;

   // graph state
   logic [N-1:0]  valid_ff, valid_in, removed_ff, removed_in, live_ff, live_in;
   logic [NW-1:0] i_ff, i_in, j_ff, j_in, s_ff, s_in, k_ff, k_in, ni_ff, ni_in;
   logic [CW-1:0] kept_ff, kept_in, st_ff, st_in, en_ff, en_in;
   logic [N-1:0]  row_ff, row_in, gath_ff, gath_in;
   logic [NW-1:0] rd_addr_ff, rd_addr_in;

   // result register
   logic          ovalid_ff, ovalid_in, olast_ff, olast_in;
   logic [103:0]  odata_ff, odata_in;

   // RAM ports
   logic          ram_rd, ram_wr;
   logic [NW-1:0] ram_rd_addr, ram_wr_addr;
   logic [N-1:0]  ram_wr_data, ram_q, row_rd;

   // derived values
   logic [CW-1:0] n_eff;
   logic [N-1:0]  low_mask, masked;
   logic          one_bit, eligible, out_free;
   logic [NW-1:0] j_enc, last_node;
   logic [NW-1:0] o_ns, o_ne;

   gdp_ram #(.WIDTH(N), .DEPTH(N)) u_adj (
      .clock  (clock),
      .wr_en  (ram_wr),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_q)
   );

   // clamp the node count to the storage
   always_comb begin
      if (count_ff == '0) begin
         n_eff = CW'(1);
      end else if (count_ff > CW'(N)) begin
         n_eff = CW'(N);
      end else begin
         n_eff = count_ff;
      end
      for (int x = 0; x < N; x++) begin
         low_mask[x] = (CW'(x) < n_eff);
      end
      last_node = NW'(n_eff - CW'(1));
   end

   // rows never written read as empty
   assign row_rd = valid_ff[rd_addr_ff] ? ram_q : '0;

   // dead-end test on the row under check
   always_comb begin
      masked   = row_rd & live_ff;
      one_bit  = (masked != '0) && ((masked & (masked - N'(1))) == '0);
      eligible = live_ff[i_ff] && (i_ff != start_ff) && (i_ff != end_ff);
      for (int b = 0; b < NW; b++) begin
         j_enc[b] = 1'b0;
         for (int x = 0; x < N; x++) begin
            if (((x >> b) & 1) == 1) begin
               j_enc[b] = j_enc[b] | masked[x];
            end
         end
      end
   end

   assign out_free = !ovalid_ff || rsp_tready;
   assign o_ns = ({1'b0, start_ff} < n_eff) ? st_ff[NW-1:0] : '0;
   assign o_ne = ({1'b0, end_ff} < n_eff) ? en_ff[NW-1:0] : '0;

   always_comb begin
      status.req_op     = req_tuser;
      status.hit        = eligible && one_bit;
      status.scan_last  = (i_ff == last_node);
      status.sweep_last = (s_ff == NW'(N - 1));
      status.i_live     = live_ff[i_ff];
      status.i_last     = (i_ff == NW'(N - 1));
      status.out_free   = out_free;
   end

   // command execution
   always_comb begin
      count_in   = count_ff;
      start_in   = start_ff;
      end_in     = end_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      conn_in    = conn_ff;
      valid_in   = valid_ff;
      removed_in = removed_ff;
      live_in    = live_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      s_in       = s_ff;
      k_in       = k_ff;
      ni_in      = ni_ff;
      kept_in    = kept_ff;
      st_in      = st_ff;
      en_in      = en_ff;
      row_in     = row_ff;
      gath_in    = gath_ff;
      rd_addr_in = rd_addr_ff;
      ovalid_in  = ovalid_ff && !rsp_tready;
      olast_in   = olast_ff;
      odata_in   = odata_ff;
      ram_rd      = 1'b0;
      ram_rd_addr = i_ff;
      ram_wr      = 1'b0;
      ram_wr_addr = i_ff;
      ram_wr_data = row_rd;

      // configuration writes
      if (csr_valid) begin
         case (csr_index)
            gdp_pkg::REG_NODE_COUNT: count_in = csr_wdata;
            gdp_pkg::REG_START_NODE: start_in = csr_wdata[NW-1:0];
            gdp_pkg::REG_END_NODE:   end_in   = csr_wdata[NW-1:0];
            default: ;
         endcase
      end

      case (cmd.code)
         gdp_pkg::CMD_LATCH: begin
            a_in    = req_tdata[5:0];
            b_in    = req_tdata[11:6];
            conn_in = req_tdata[12];
         end
         gdp_pkg::CMD_RD_A: begin
            ram_rd      = 1'b1;
            ram_rd_addr = a_ff;
         end
         gdp_pkg::CMD_WR_A: begin
            ram_wr      = 1'b1;
            ram_wr_addr = a_ff;
            ram_wr_data = conn_ff ? (row_rd | gdp_pkg::node_bit(b_ff))
                                  : (row_rd & ~gdp_pkg::node_bit(b_ff));
            removed_in  = '0;
         end
         gdp_pkg::CMD_RD_B: begin
            ram_rd      = 1'b1;
            ram_rd_addr = b_ff;
         end
         gdp_pkg::CMD_WR_B: begin
            ram_wr      = 1'b1;
            ram_wr_addr = b_ff;
            ram_wr_data = conn_ff ? (row_rd | gdp_pkg::node_bit(a_ff))
                                  : (row_rd & ~gdp_pkg::node_bit(a_ff));
         end
         gdp_pkg::CMD_PINIT: begin
            live_in = low_mask & ~removed_ff;
            i_in    = '0;
         end
         gdp_pkg::CMD_RD_I: begin
            ram_rd = 1'b1;
         end
         gdp_pkg::CMD_CHECK: begin
            if (eligible && one_bit) begin
               // drop the node and its single edge
               ram_wr      = 1'b1;
               ram_wr_data = row_rd & ~gdp_pkg::node_bit(j_enc);
               removed_in  = removed_ff | gdp_pkg::node_bit(i_ff);
               live_in     = live_ff & ~gdp_pkg::node_bit(i_ff);
               j_in        = j_enc;
            end else begin
               i_in    = i_ff + NW'(1);
               s_in    = '0;
               kept_in = '0;
               st_in   = '0;
               en_in   = '0;
            end
         end
         gdp_pkg::CMD_RD_J: begin
            ram_rd      = 1'b1;
            ram_rd_addr = j_ff;
         end
         gdp_pkg::CMD_WR_J: begin
            ram_wr      = 1'b1;
            ram_wr_addr = j_ff;
            ram_wr_data = row_rd & ~gdp_pkg::node_bit(i_ff);
            i_in        = '0;
         end
         gdp_pkg::CMD_COUNT: begin
            kept_in = kept_ff + CW'(live_ff[s_ff]);
            st_in   = st_ff + CW'(live_ff[s_ff] && (s_ff < start_ff));
            en_in   = en_ff + CW'(live_ff[s_ff] && (s_ff < end_ff));
            s_in    = s_ff + NW'(1);
            i_in    = '0;
            ni_in   = '0;
         end
         gdp_pkg::CMD_FIND: begin
            if (live_ff[i_ff]) begin
               ram_rd = 1'b1;
            end else begin
               i_in = i_ff + NW'(1);
            end
         end
         gdp_pkg::CMD_OLAT: begin
            row_in  = row_rd & live_ff;
            gath_in = '0;
            s_in    = '0;
            k_in    = '0;
         end
         gdp_pkg::CMD_GATH: begin
            // squeeze one column a cycle
            if (live_ff[s_ff]) begin
               gath_in[k_ff] = row_ff[s_ff];
               k_in          = k_ff + NW'(1);
            end
            s_in = s_ff + NW'(1);
         end
         gdp_pkg::CMD_LOAD: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               olast_in  = ({1'b0, ni_ff} == (kept_ff - CW'(1)));
               odata_in  = {2'b00, CW'(n_eff - kept_ff), kept_ff, o_ne, o_ns,
                            gath_ff, ni_ff, i_ff};
               ni_in     = ni_ff + NW'(1);
               i_in      = i_ff + NW'(1);
            end
         end
         default: ;
      endcase

      if (ram_rd) begin
         rd_addr_in = ram_rd_addr;
      end
      if (ram_wr) begin
         valid_in = valid_in | gdp_pkg::node_bit(ram_wr_addr);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= CW'(N);
         start_ff   <= '0;
         end_ff     <= NW'(1);
         valid_ff   <= '0;
         removed_ff <= '0;
         ovalid_ff  <= 1'b0;
      end else begin
         count_ff   <= count_in;
         start_ff   <= start_in;
         end_ff     <= end_in;
         valid_ff   <= valid_in;
         removed_ff <= removed_in;
         ovalid_ff  <= ovalid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      b_ff       <= b_in;
      conn_ff    <= conn_in;
      live_ff    <= live_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      s_ff       <= s_in;
      k_ff       <= k_in;
      ni_ff      <= ni_in;
      kept_ff    <= kept_in;
      st_ff      <= st_in;
      en_ff      <= en_in;
      row_ff     <= row_in;
      gath_ff    <= gath_in;
      rd_addr_ff <= rd_addr_in;
      olast_ff   <= olast_in;
      odata_ff   <= odata_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tlast  = olast_ff;

endmodule

// ===== rtl/gdp_ctrl.sv =====
// ----------------------------------------------------------------------------
// gdp_ctrl: sequencer for edge writes, pruning and result output
// Issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module gdp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  gdp_pkg::status_type status,
   output gdp_pkg::cmd_type    cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_WRDA = 4'd1;
   localparam logic [3:0] S_WWRA = 4'd2;
   localparam logic [3:0] S_WRDB = 4'd3;
   localparam logic [3:0] S_WWRB = 4'd4;
   localparam logic [3:0] S_PINI = 4'd5;
   localparam logic [3:0] S_PRDI = 4'd6;
   localparam logic [3:0] S_PCHK = 4'd7;
   localparam logic [3:0] S_PRDJ = 4'd8;
   localparam logic [3:0] S_PWRJ = 4'd9;
   localparam logic [3:0] S_CNT  = 4'd10;
   localparam logic [3:0] S_FIND = 4'd11;
   localparam logic [3:0] S_OLAT = 4'd12;
   localparam logic [3:0] S_GATH = 4'd13;
   localparam logic [3:0] S_LOAD = 4'd14;

   logic [3:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   // next state and command
   always_comb begin
      state_in = state_ff;
      cmd.code = gdp_pkg::CMD_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.code = gdp_pkg::CMD_LATCH;
               state_in = (status.req_op == gdp_pkg::OP_PRUNE) ? S_PINI : S_WRDA;
            end
         end
         S_WRDA: begin
            cmd.code = gdp_pkg::CMD_RD_A;
            state_in = S_WWRA;
         end
         S_WWRA: begin
            cmd.code = gdp_pkg::CMD_WR_A;
            state_in = S_WRDB;
         end
         S_WRDB: begin
            cmd.code = gdp_pkg::CMD_RD_B;
            state_in = S_WWRB;
         end
         S_WWRB: begin
            cmd.code = gdp_pkg::CMD_WR_B;
            state_in = S_IDLE;
         end
         S_PINI: begin
            cmd.code = gdp_pkg::CMD_PINIT;
            state_in = S_PRDI;
         end
         S_PRDI: begin
            cmd.code = gdp_pkg::CMD_RD_I;
            state_in = S_PCHK;
         end
         S_PCHK: begin
            cmd.code = gdp_pkg::CMD_CHECK;
            if (status.hit) begin
               state_in = S_PRDJ;
            end else if (status.scan_last) begin
               state_in = S_CNT;
            end else begin
               state_in = S_PRDI;
            end
         end
         S_PRDJ: begin
            cmd.code = gdp_pkg::CMD_RD_J;
            state_in = S_PWRJ;
         end
         S_PWRJ: begin
            cmd.code = gdp_pkg::CMD_WR_J;
            state_in = S_PRDI;
         end
         S_CNT: begin
            cmd.code = gdp_pkg::CMD_COUNT;
            if (status.sweep_last) begin
               state_in = S_FIND;
            end
         end
         S_FIND: begin
            cmd.code = gdp_pkg::CMD_FIND;
            if (status.i_live) begin
               state_in = S_OLAT;
            end else if (status.i_last) begin
               state_in = S_IDLE;
            end
         end
         S_OLAT: begin
            cmd.code = gdp_pkg::CMD_OLAT;
            state_in = S_GATH;
         end
         S_GATH: begin
            cmd.code = gdp_pkg::CMD_GATH;
            if (status.sweep_last) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.code = gdp_pkg::CMD_LOAD;
            if (status.out_free) begin
               state_in = status.i_last ? S_IDLE : S_FIND;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/graph_dead_end_pruner.sv =====
// ----------------------------------------------------------------------------
// graph_dead_end_pruner: prunes dead-end nodes and reports the compacted graph
//
//   channel  direction  handshake             payload
//   req_     in         req_tvalid/tready     tdata node_a, node_b, connected;
//                                             tuser operation
//   rsp_     out        rsp_tvalid/tready     tdata result fields; tlast last
//   csr_     in         csr_valid/ready       csr_index, csr_wdata
//
// An edge write is two read-modify-writes on the row memory, for node_a
// and node_b. A prune scans rows from node 0, rescanning from node 0 after
// each removal, which also clears the edge in the neighbour's row; it then
// counts survivors and gathers the compacted row of each surviving node.
// Reset clears the row valid bits, so no clearing pass is needed.
// A stalled result holds the sequencer until the result register frees.
// ----------------------------------------------------------------------------
module graph_dead_end_pruner (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // node_a[5:0], node_b[11:6], connected[12]
   input  logic         req_tuser,   // operation
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // old_index[5:0], new_index[11:6],
                                     // neighbours[75:12], new_start[81:76],
                                     // new_end[87:82], kept_count[94:88],
                                     // removed_count[101:95]
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [6:0]   csr_wdata
);

   gdp_pkg::cmd_type    cmd;
   gdp_pkg::status_type status;

   assign csr_ready = 1'b1;

   gdp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   gdp_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   // final result carries the highest new index
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> ({1'b0, rsp_tdata[11:6]} == rsp_tdata[94:88] - 7'd1))
      else $error("last result index does not match survivor count");

   // survivors and pruned nodes never exceed storage
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({1'b0, rsp_tdata[94:88]} + {1'b0, rsp_tdata[101:95]} <= 8'd64))
      else $error("node counts exceed storage");

   // every new index lies below the survivor count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({1'b0, rsp_tdata[11:6]} < rsp_tdata[94:88]))
      else $error("new index out of range");

endmodule
